[design/rws_pkg.sv]
package rws_pkg;

	localparam int CMD_W    = 2;
	localparam int FIT_IN_W = 16;
	localparam int RND_IN_W = 16;
	localparam int IDX_W    = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_DRAW  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;
		logic high;
	} rws_mul_ctl_t;

endpackage

[design/rws_in_if.sv]
interface rws_in_if import rws_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [FIT_IN_W-1:0] fitness_value;
	logic [RND_IN_W-1:0] random_fraction;

	modport source (output valid, output cmd, output fitness_value, output random_fraction,
		input ready);
	modport sink (input valid, input cmd, input fitness_value, input random_fraction,
		output ready);
endinterface

[design/rws_out_if.sv]
interface rws_out_if import rws_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] selected_index;
	logic             found;
	logic             overflow;

	modport source (output valid, output selected_index, output found, output overflow,
		input ready);
	modport sink (input valid, input selected_index, input found, input overflow,
		output ready);
endinterface

[design/roulette_wheel_selector_top.sv]
// Roulette wheel (fitness-proportionate) selector.
// item channel (valid/ready) takes one word: cmd, fitness_value, random_fraction.
//   clear: empties the table, returns no word.
//   load : appends running cumulative fitness; returns the slot written, or
//          overflow=1 with index 0 when the table is full.
//   draw : returns the first index j with r*total < cum[j]*2^RANDOM_BITS,
//          found=0 when the table is empty or the total is zero.
// result channel (valid/ready) carries selected_index, found, overflow.
// A clear leaves the block idle; a load and an empty/zero-total draw go
// to the finish state; a draw that searches runs the multiply states (low,
// high), then S binary search steps, at most floor(log2(entries)) + 1 (9 for
// a full table of 256), then the finish state. ready is high only in idle,
// so no new word is taken until the finish state has been left.
// The search walks the cumulative table RAM one read per cycle; the
// product r*total comes from one shared multiplier in two passes.
// A finished result sits in the output register; the next word is taken
// while it waits, and a stalled receiver only holds the block at the end
// of that next word (ready stays low until the output register frees).
// Reset clears entry count, total and the output valid; the table RAM
// needs no clearing since only entries below the count are used.
module roulette_wheel_selector_top import rws_pkg::*; #(
	parameter int MAX_POPULATION = 256,
	parameter int FITNESS_BITS   = 16,
	parameter int RANDOM_BITS    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rws_in_if.sink    item,
	rws_out_if.source result
);

	localparam int AW  = $clog2(MAX_POPULATION);
	localparam int CNW = $clog2(MAX_POPULATION + 1);
	localparam int CW  = FITNESS_BITS + AW;
	localparam int PW  = RANDOM_BITS + CW;
	localparam logic [CNW-1:0] MAX_CNT = CNW'(MAX_POPULATION);

	state_t state_q, state_d;

	logic [CNW-1:0]         count_q;
	logic [CW-1:0]          total_q;
	logic [RANDOM_BITS-1:0] r_q;
	logic [CNW-1:0]         lo_q, hi_q, mid_q;
	logic [IDX_W-1:0]       res_idx_q;
	logic                   res_found_q, res_ovf_q;
	logic [IDX_W-1:0]       out_idx_q;
	logic                   out_found_q, out_ovf_q, out_valid_q;

	logic                   accept, full, out_free, below, more;
	cmd_t                   cmd;
	logic [FITNESS_BITS-1:0] fit_m;
	logic [CW-1:0]          new_total;
	logic [CW-1:0]          rd_data;
	logic [CNW-1:0]         rd_addr, half_cnt, lo_n, hi_n, mid_n;
	logic [CNW:0]           sum_n;
	logic [PW-1:0]          prod, cum_scaled;
	rws_mul_ctl_t           mul_ctl;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign cmd        = cmd_t'(item.cmd);
	assign fit_m      = FITNESS_BITS'(item.fitness_value);
	assign new_total  = total_q + CW'(fit_m);
	assign full       = (count_q == MAX_CNT);
	assign out_free   = !out_valid_q || result.ready;
	assign half_cnt   = count_q >> 1;

	rws_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_POPULATION)
	) u_table (
		.clk   (clk),
		.we    (accept && (cmd == CMD_LOAD) && !full),
		.waddr (count_q[AW-1:0]),
		.wdata (new_total),
		.raddr (rd_addr[AW-1:0]),
		.rdata (rd_data)
	);

	rws_mul_acc #(
		.A_BITS (RANDOM_BITS),
		.T_BITS (CW)
	) u_mul (
		.clk   (clk),
		.ctl   (mul_ctl),
		.a     (r_q),
		.total (total_q),
		.acc   (prod)
	);

	// binary search step: first index whose scaled cumulative sum exceeds r*total
	assign cum_scaled = {rd_data, {RANDOM_BITS{1'b0}}};
	assign below      = prod < cum_scaled;
	assign lo_n       = below ? lo_q : mid_q + CNW'(1);
	assign hi_n       = below ? mid_q : hi_q;
	assign sum_n      = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n      = sum_n[CNW:1];
	assign more       = lo_n < hi_n;

	always_comb begin
		state_d = state_q;
		mul_ctl = '0;
		rd_addr = mid_n;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_LOAD: state_d = ST_FINISH;
						CMD_DRAW: begin
							if (count_q == '0 || total_q == '0) begin
								state_d = ST_FINISH;
							end else begin
								state_d = ST_MUL_LO;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MUL_LO: begin
				mul_ctl.en = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				mul_ctl.en   = 1'b1;
				mul_ctl.high = 1'b1;
				rd_addr      = half_cnt;
				state_d      = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (!more) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && cmd == CMD_CLEAR) begin
				count_q <= '0;
				total_q <= '0;
			end else if (accept && cmd == CMD_LOAD && !full) begin
				count_q <= count_q + CNW'(1);
				total_q <= new_total;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			r_q         <= RANDOM_BITS'(item.random_fraction);
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_ovf_q   <= 1'b0;
			if (cmd == CMD_LOAD) begin
				if (full) begin
					res_ovf_q <= 1'b1;
				end else begin
					res_idx_q <= IDX_W'(count_q);
				end
			end
		end
		if (state_q == ST_MUL_HI) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			mid_q <= half_cnt;
		end
		if (state_q == ST_SEARCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
			if (!more) begin
				res_idx_q   <= IDX_W'(lo_n);
				res_found_q <= lo_n < count_q;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_idx_q   <= res_idx_q;
			out_found_q <= res_found_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.selected_index = out_idx_q;
	assign result.found          = out_found_q;
	assign result.overflow       = out_ovf_q;

endmodule

[design/rws_ram.sv]
module rws_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/rws_mul_acc.sv]
module rws_mul_acc import rws_pkg::*; #(
	parameter int A_BITS = 16,
	parameter int T_BITS = 24
) (
	input  logic                     clk,
	input  rws_mul_ctl_t             ctl,
	input  logic [A_BITS-1:0]        a,
	input  logic [T_BITS-1:0]        total,
	output logic [A_BITS+T_BITS-1:0] acc
);

	localparam int HALF = (T_BITS + 1) / 2;
	localparam int MW   = A_BITS + HALF;
	localparam int PW   = A_BITS + T_BITS;

	logic [HALF-1:0] b;
	logic [MW-1:0]   prod;
	logic [PW-1:0]   part;
	logic [PW-1:0]   acc_q;

	// low half of total first, then high half shifted into place
	assign b    = ctl.high ? HALF'(total[T_BITS-1:HALF]) : total[HALF-1:0];
	assign prod = MW'(a) * MW'(b);
	assign part = ctl.high ? (PW'(prod) << HALF) : PW'(prod);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= ctl.high ? acc_q + part : part;
		end
	end

	assign acc = acc_q;

endmodule
